// ===== hw/rtl/fqm_pkg.sv =====
// Package for the FIFO queue with minimum query.
// Holds the queue sizes, operation and status codes, the controller states and shared types.
// No dependencies.
`default_nettype none

package fqm_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] min_value;
    logic [OCC_W-1:0]         occupancy;
    logic [1:0]               status;
  } res_t;

  function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] r;
    if (idx == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCC_W-1:0] w;
    w = {{OCC_W{1'b0}}, c};
    return w[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fqm_if.sv =====
// Channel interfaces for the FIFO queue with minimum query.
// One interface for operations in and one for results out; depends on fqm_pkg.
`default_nettype none

interface fqm_in_if
  import fqm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface fqm_out_if
  import fqm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] min_value;
  logic [OCC_W-1:0]         occupancy;
  logic [1:0]               status;

  modport source (output valid, popped_value, min_value, occupancy, status, input ready);
  modport sink (input valid, popped_value, min_value, occupancy, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fqm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module fqm_ram #(
  parameter int DATA_W  = 32,
  parameter int ADDR_W  = 4,
  parameter int DEPTH_P = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fqm_ctrl.sv =====
// Controller of the FIFO queue with minimum query: pointers, count and the minimum scan.
// Drives the ring store through a ram_req_t; depends on fqm_pkg and fqm_if.
`default_nettype none

module fqm_ctrl
  import fqm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  fqm_in_if.sink                        in_ch,
  output ram_req_t                      ram_req,
  input  wire logic signed [DATA_W-1:0] ram_rdata,
  output logic                          res_valid,
  output res_t                          res,
  input  wire logic                     res_ready
);

  state_t                   state_r, state_nxt;
  logic [1:0]               kind_r, kind_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [PTR_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] popped_r, popped_nxt;
  status_t                  status_r, status_nxt;
  logic [PTR_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]         issued_r, issued_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic                     start_scan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    value_r    <= value_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
    scan_idx_r <= scan_idx_nxt;
    issued_r   <= issued_nxt;
    best_r     <= best_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    value_nxt    = value_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    popped_nxt   = popped_r;
    status_nxt   = status_r;
    scan_idx_nxt = scan_idx_r;
    issued_nxt   = issued_r;
    rd_vld_nxt   = rd_vld_r;
    best_nxt     = best_r;
    start_scan   = 1'b0;
    ram_req      = '0;
    in_ch.ready  = 1'b0;
    res_valid    = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          value_nxt = in_ch.value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        popped_nxt = '0;
        status_nxt = ST_OK;
        start_scan = 1'b1;
        case (kind_r)
          KIND_PUSH: begin
            if (cnt_r >= CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = tail_r;
              ram_req.wdata = value_r;
              tail_nxt      = next_idx(tail_r);
              cnt_nxt       = cnt_r + CNT_W'(1);
            end
          end
          KIND_POP: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              ram_req.re    = 1'b1;
              ram_req.raddr = head_r;
              start_scan    = 1'b0;
              state_nxt     = S_POPRD;
            end
          end
          KIND_CLEAR: begin
            head_nxt = '0;
            tail_nxt = '0;
            cnt_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      S_POPRD: begin
        popped_nxt = ram_rdata;
        head_nxt   = next_idx(head_r);
        cnt_nxt    = cnt_r - CNT_W'(1);
        start_scan = 1'b1;
      end
      S_SCAN: begin
        if (rd_vld_r && (ram_rdata < best_r)) begin
          best_nxt = ram_rdata;
        end
        if (issued_r == cnt_r) begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = scan_idx_r;
          scan_idx_nxt  = next_idx(scan_idx_r);
          issued_nxt    = issued_r + CNT_W'(1);
          rd_vld_nxt    = 1'b1;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      scan_idx_nxt = head_nxt;
      issued_nxt   = '0;
      rd_vld_nxt   = 1'b0;
      best_nxt     = INT_MAX;
      state_nxt    = S_SCAN;
    end
  end

  always_comb begin
    res.popped_value = popped_r;
    res.min_value    = (cnt_r == '0) ? '0 : best_r;
    res.occupancy    = to_occ(cnt_r);
    res.status       = status_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fqm_outreg.sv =====
// Output register of the FIFO queue with minimum query.
// Holds one finished result until the result channel takes it; depends on fqm_pkg and fqm_if.
`default_nettype none

module fqm_outreg
  import fqm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  res_t      res,
  output logic      res_ready,
  fqm_out_if.source out_ch
);

  logic vld_r;
  res_t data_r;

  assign res_ready = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_ready) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.popped_value = data_r.popped_value;
  assign out_ch.min_value    = data_r.min_value;
  assign out_ch.occupancy    = data_r.occupancy;
  assign out_ch.status       = data_r.status;

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_queue_with_minimum.sv =====
// Top level of the FIFO queue with minimum query.
// Instantiates the controller, the ring store RAM and the output register; depends on fqm_pkg and fqm_if.
//
//   Channel   Direction  Payload                                        Transaction
//   in_chan   in         kind, value                                    valid & ready
//   out_chan  out        popped_value, min_value, occupancy, status     valid & ready
//
// One operation is taken at a time. From acceptance it passes through S_EXEC, for a successful pop
// also S_POPRD, then S_SCAN over the held entries and S_DONE before reaching the output register.
// The controller returns to idle at the edge that loads the output register and can then take the next.
// The minimum scan reads one held entry per cycle through the single RAM read port.
// Reset clears pointers, count and control; the ring store is not cleared.
// A finished result waits in the output register; the next operation is accepted meanwhile
// and only stalls at its end if the previous result has still not been taken.
`default_nettype none

module fifo_queue_with_minimum
  import fqm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  fqm_in_if.sink    in_chan,
  fqm_out_if.source out_chan
);

  ram_req_t                 ram_req;
  logic [DATA_W-1:0]        ram_rdata;
  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;

  fqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .ram_req   (ram_req),
    .ram_rdata ($signed(ram_rdata)),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  fqm_ram #(
    .DATA_W  (DATA_W),
    .ADDR_W  (PTR_W),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  fqm_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_chan)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fqm_checker.sv =====
// Port checker for the FIFO queue with minimum query, bound to the top level.
// Depends on fqm_pkg and fifo_queue_with_minimum.
`default_nettype none

module fqm_checker
  import fqm_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] out_popped_value,
  input wire logic signed [DATA_W-1:0] out_min_value,
  input wire logic [OCC_W-1:0]         out_occupancy,
  input wire logic [1:0]               out_status
);

  // An accepted operation keeps the input closed in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in consecutive cycles");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_popped_value == '0))
    else $error("pop on empty queue returned a value");

  a_empty_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_occupancy == '0) && (out_status != ST_FULL)) |->
      (out_min_value == '0))
    else $error("empty queue reported a non-zero minimum");

  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_occupancy == to_occ(CNT_W'(DEPTH))))
    else $error("push dropped while the queue was not full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_min_value) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_minimum fqm_checker u_fqm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_popped_value (out_chan.popped_value),
  .out_min_value    (out_chan.min_value),
  .out_occupancy    (out_chan.occupancy),
  .out_status       (out_chan.status)
);

`default_nettype wire
